@@ rtl/core/ray_affine_transform_core_macros.svh @@
// Shared assertion shorthands for the ray transform core.
`ifndef RAY_AFFINE_TRANSFORM_CORE_MACROS_SVH
`define RAY_AFFINE_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RAT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ray transform core: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RAT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ray transform core: next-cycle check failed");

`endif

@@ rtl/core/rat_pkg.sv @@
package rat_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    // three full products plus the rounding half, with headroom
    localparam int SUM_W     = 66;
    // shifted sum plus translation
    localparam int ACC_W     = 67;
    localparam int NUM_COEFS = 24;
    localparam int MAT_SIZE  = 12;
    localparam int IDX_W     = 5;
    localparam int OUT_W     = 9 * DATA_W;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } rat_op_t;

    // stage advance enables shared by all lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } rat_adv_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } rat_sat_t;

    function automatic rat_sat_t sat32(input logic signed [ACC_W-1:0] v);
        rat_sat_t r;
        logic signed [ACC_W-1:0] hi_lim;
        logic signed [ACC_W-1:0] lo_lim;
        hi_lim = ACC_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
        lo_lim = ACC_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}));
        if (v > hi_lim) begin
            r.val = {1'b0, {(DATA_W-1){1'b1}}};
            r.ovf = 1'b1;
        end else if (v < lo_lim) begin
            r.val = {1'b1, {(DATA_W-1){1'b0}}};
            r.ovf = 1'b1;
        end else begin
            r.val = v[DATA_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/rat_lane.sv @@
// One output component of one point: three products, sum with rounding, shift,
// translation and saturation over three stages.
module rat_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  rat_pkg::rat_adv_t                    adv,
    input  logic signed [rat_pkg::DATA_W-1:0]    coef0,
    input  logic signed [rat_pkg::DATA_W-1:0]    coef1,
    input  logic signed [rat_pkg::DATA_W-1:0]    coef2,
    input  logic signed [rat_pkg::DATA_W-1:0]    coef3,
    input  logic signed [rat_pkg::DATA_W-1:0]    pt0,
    input  logic signed [rat_pkg::DATA_W-1:0]    pt1,
    input  logic signed [rat_pkg::DATA_W-1:0]    pt2,
    output rat_pkg::rat_sat_t                    res
);

    localparam logic signed [rat_pkg::SUM_W-1:0] HALF =
        rat_pkg::SUM_W'(1) << (FRAC_BITS - 1);

    logic signed [rat_pkg::PROD_W-1:0] prod0_reg, prod1_reg, prod2_reg;
    logic signed [rat_pkg::DATA_W-1:0] c3_s1_reg, c3_s2_reg;
    logic signed [rat_pkg::SUM_W-1:0]  sum_reg;
    logic signed [rat_pkg::SUM_W-1:0]  shr;
    logic signed [rat_pkg::ACC_W-1:0]  acc;
    rat_pkg::rat_sat_t                 res_reg;

    always_ff @(posedge aclk) begin
        if (adv.en1) begin
            prod0_reg <= rat_pkg::PROD_W'(coef0) * rat_pkg::PROD_W'(pt0);
            prod1_reg <= rat_pkg::PROD_W'(coef1) * rat_pkg::PROD_W'(pt1);
            prod2_reg <= rat_pkg::PROD_W'(coef2) * rat_pkg::PROD_W'(pt2);
            c3_s1_reg <= coef3;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.en2) begin
            sum_reg   <= rat_pkg::SUM_W'(prod0_reg) + rat_pkg::SUM_W'(prod1_reg)
                       + rat_pkg::SUM_W'(prod2_reg) + HALF;
            c3_s2_reg <= c3_s1_reg;
        end
    end

    // floor of the rounded sum, then add translation
    assign shr = sum_reg >>> FRAC_BITS;
    assign acc = rat_pkg::ACC_W'(shr) + rat_pkg::ACC_W'(c3_s2_reg);

    always_ff @(posedge aclk) begin
        if (adv.en3) begin
            res_reg <= rat_pkg::sat32(acc);
        end
    end

    assign res = res_reg;

endmodule

@@ rtl/core/rat_merge.sv @@
// Combine lane results: direction per axis, overflow reduction, result packing.
module rat_merge (
    input  logic                             aclk,
    input  logic                             en,
    input  rat_pkg::rat_sat_t [2:0]          start_res,
    input  rat_pkg::rat_sat_t [2:0]          end_res,
    output logic [rat_pkg::OUT_W-1:0]        data,
    output logic                             ovf
);

    rat_pkg::rat_sat_t [2:0]          dir;
    logic [rat_pkg::OUT_W-1:0]        data_reg;
    logic                             ovf_reg;
    logic                             ovf_any;

    always_comb begin
        ovf_any = 1'b0;
        for (int k = 0; k < 3; k++) begin
            dir[k]  = rat_pkg::sat32(rat_pkg::ACC_W'(end_res[k].val)
                                   - rat_pkg::ACC_W'(start_res[k].val));
            ovf_any = ovf_any | start_res[k].ovf | end_res[k].ovf | dir[k].ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= {dir[2].val, dir[1].val, dir[0].val,
                         end_res[2].val, end_res[1].val, end_res[0].val,
                         start_res[2].val, start_res[1].val, start_res[0].val};
            ovf_reg  <= ovf_any;
        end
    end

    assign data = data_reg;
    assign ovf  = ovf_reg;

endmodule

@@ rtl/core/rat_skid.sv @@
// Two-entry output buffer; upstream ready comes from a register only.
module rat_skid #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/core/ray_affine_transform_core.sv @@
// Ray affine transform core. Holds a forward and an inverse 3x4 affine matrix
// (signed fixed point with FRAC_BITS fraction bits, Q16.16 by default), both
// identity after reset. A load transfer (tuser = 0) writes one coefficient and
// gives no result; indexes 24..31 are dropped. A transform transfer (tuser = 1)
// maps the ray's start and end points, each as (x, y, z, 1), through the
// selected matrix and returns both points plus their difference, every
// component rounded to nearest (ties up) and saturated to 32 bits, with the
// saturation flag in m_tuser. One transfer is accepted per cycle unless a full
// pipeline is held by m_tready. Six lanes (two points by three rows), each with
// three pipelined 32x32 multipliers, set that rate; a transform passes the
// three lane stages, the merge stage and the output buffer in turn. A load is
// seen by a transform accepted in the very next cycle.
module ray_affine_transform_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [4:0] coef_index, [36:5] coef_value, [68:37] start_x, [100:69] start_y,
    // [132:101] start_z, [164:133] end_x, [196:165] end_y, [228:197] end_z,
    // [229] use_inverse, [231:230] zero
    input  logic [231:0] s_tdata,
    // [0] opcode
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] out_start_x, [63:32] out_start_y, [95:64] out_start_z,
    // [127:96] out_end_x, [159:128] out_end_y, [191:160] out_end_z,
    // [223:192] dir_x, [255:224] dir_y, [287:256] dir_z
    output logic [287:0] m_tdata,
    // [0] overflow
    output logic         m_tuser
);

    `include "ray_affine_transform_core_macros.svh"

    localparam int DW = rat_pkg::DATA_W;
    localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    // input fields
    logic [rat_pkg::IDX_W-1:0]  coef_index;
    logic signed [DW-1:0]       coef_value;
    logic signed [DW-1:0]       pts [2][3];
    logic                       use_inverse;
    logic                       accept;
    logic                       is_load;
    logic                       is_xform;

    assign coef_index  = s_tdata[4:0];
    assign coef_value  = s_tdata[36:5];
    assign pts[0][0]   = s_tdata[68:37];
    assign pts[0][1]   = s_tdata[100:69];
    assign pts[0][2]   = s_tdata[132:101];
    assign pts[1][0]   = s_tdata[164:133];
    assign pts[1][1]   = s_tdata[196:165];
    assign pts[1][2]   = s_tdata[228:197];
    assign use_inverse = s_tdata[229];

    assign accept   = s_tvalid && s_tready;
    assign is_load  = rat_pkg::rat_op_t'(s_tuser) == rat_pkg::OP_LOAD;
    assign is_xform = rat_pkg::rat_op_t'(s_tuser) == rat_pkg::OP_XFORM;

    // coefficient store: forward matrix in entries 0..11, inverse in 12..23
    logic signed [DW-1:0] coef_reg [rat_pkg::NUM_COEFS];

    for (genvar g = 0; g < rat_pkg::NUM_COEFS; g++) begin : g_coef
        localparam bit DIAG = ((g % rat_pkg::MAT_SIZE) % 5) == 0;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                coef_reg[g] <= DIAG ? ONE : '0;
            end else if (accept && is_load && coef_index == rat_pkg::IDX_W'(g)) begin
                coef_reg[g] <= coef_value;
            end
        end
    end

    // pipeline occupancy; each stage advances when the next one can take it
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic skid_ready;
    rat_pkg::rat_adv_t adv;

    assign rdy4     = !v4_reg || skid_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign adv      = '{en1: rdy1, en2: rdy2, en3: rdy3};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= accept && is_xform;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // six lanes: point p, output row r; select the matrix at the entry stage
    rat_pkg::rat_sat_t [2:0] lane_res [2];

    for (genvar p = 0; p < 2; p++) begin : g_pt
        for (genvar r = 0; r < 3; r++) begin : g_row
            localparam int FB = r * 4;
            localparam int IB = rat_pkg::MAT_SIZE + r * 4;
            rat_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .aclk  (aclk),
                .adv   (adv),
                .coef0 (use_inverse ? coef_reg[IB]     : coef_reg[FB]),
                .coef1 (use_inverse ? coef_reg[IB + 1] : coef_reg[FB + 1]),
                .coef2 (use_inverse ? coef_reg[IB + 2] : coef_reg[FB + 2]),
                .coef3 (use_inverse ? coef_reg[IB + 3] : coef_reg[FB + 3]),
                .pt0   (pts[p][0]),
                .pt1   (pts[p][1]),
                .pt2   (pts[p][2]),
                .res   (lane_res[p][r])
            );
        end
    end

    // merge: direction, overflow, packing
    logic [rat_pkg::OUT_W-1:0] merge_data;
    logic                      merge_ovf;

    rat_merge u_merge (
        .aclk      (aclk),
        .en        (rdy4),
        .start_res (lane_res[0]),
        .end_res   (lane_res[1]),
        .data      (merge_data),
        .ovf       (merge_ovf)
    );

    // output buffer: hold a finished result while new transfers keep coming
    rat_skid #(
        .WIDTH (rat_pkg::OUT_W + 1)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v4_reg),
        .in_ready  (skid_ready),
        .in_data   ({merge_ovf, merge_data}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  ({m_tuser, m_tdata})
    );

    // a transform enters stage one; a load leaves it empty
    `RAT_ASSERT_NEXT(a_entry, aclk, aresetn, accept, v1_reg == $past(is_xform))
    // input stalls only when every pipeline stage is occupied
    `RAT_ASSERT_NOW(a_stall, aclk, aresetn, !s_tready, v1_reg && v2_reg && v3_reg && v4_reg)
    // a result in stage three moves into the merge stage when it is free
    `RAT_ASSERT_NEXT(a_adv, aclk, aresetn, v3_reg && rdy4, v4_reg)

endmodule
